// ===== rtl/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg: shared types and codes for the array list engine
// Opcodes, status codes, cell commands and the link between neighbor cells.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int ALE_DEPTH = 16;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_COUNT  = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_INSERT    = 3'd1,
      CELL_DELETE    = 3'd2,
      CELL_SORT_EVEN = 3'd3,
      CELL_SORT_ODD  = 3'd4
   } cell_cmd_type;

   // broadcast to every cell
   typedef struct packed {
      cell_cmd_type cmd;
      logic [31:0]  key;
   } cell_ctl_type;

   // handed from a cell to its upper neighbor
   typedef struct packed {
      logic [31:0] data;
      logic        eq;
      logic        seen;
      logic [31:0] tap;
   } cell_link_type;

endpackage

// ===== rtl/ale_cell.sv =====
// ----------------------------------------------------------------------------
// ale_cell: one slot of the list
// Holds one entry, shifts and sorts with its neighbors, and carries the
// match, prefix-match, match count and tap values along the chain.
// ----------------------------------------------------------------------------
module ale_cell #(
   parameter int DEPTH = ale_pkg::ALE_DEPTH,
   parameter int IDX   = 0
) (
   input  logic                          clock,
   input  ale_pkg::cell_ctl_type         ctl,
   input  logic [$clog2(DEPTH)-1:0]      pos,
   input  logic [$clog2(DEPTH)-1:0]      probe,
   input  logic [$clog2(DEPTH+1)-1:0]    fill,
   input  ale_pkg::cell_link_type        left_link,
   input  logic [$clog2(DEPTH+1)-1:0]    left_cnt,
   input  logic [31:0]                   right_data,
   output ale_pkg::cell_link_type        out_link,
   output logic [$clog2(DEPTH+1)-1:0]    out_cnt
);

   localparam int IW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH+1);
   localparam bit IS_ODD = (IDX % 2) == 1;

   logic [31:0]   data_ff, data_in;
   logic          seen_ff;
   logic [FW-1:0] cnt_ff;
   logic [31:0]   tap_ff;
   logic          eq;
   logic          low_role;

   assign eq = (data_ff == ctl.key) && (32'(IDX) < 32'(fill));

   assign low_role = (ctl.cmd == ale_pkg::CELL_SORT_EVEN) ? !IS_ODD : IS_ODD;

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         ale_pkg::CELL_INSERT: begin
            if (pos == IW'(IDX)) begin
               data_in = ctl.key;
            end else if (32'(IDX) > 32'(pos)) begin
               data_in = left_link.data;
            end
         end
         ale_pkg::CELL_DELETE: begin
            if (seen_ff || eq) begin
               data_in = right_data;
            end
         end
         ale_pkg::CELL_SORT_EVEN, ale_pkg::CELL_SORT_ODD: begin
            if (low_role) begin
               if ((32'(IDX + 1) < 32'(fill)) && ($signed(right_data) < $signed(data_ff))) begin
                  data_in = right_data;
               end
            end else if ((IDX >= 1) && (32'(IDX) < 32'(fill)) &&
                         ($signed(data_ff) < $signed(left_link.data))) begin
               data_in = left_link.data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // chain values settle one cell per cycle
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      seen_ff <= left_link.seen | left_link.eq;
      cnt_ff  <= left_cnt + FW'(left_link.eq);
      tap_ff  <= (probe == IW'(IDX)) ? data_ff : left_link.tap;
   end

   assign out_link.data = data_ff;
   assign out_link.eq   = eq;
   assign out_link.seen = seen_ff;
   assign out_link.tap  = tap_ff;
   assign out_cnt       = cnt_ff;

endmodule

// ===== rtl/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed words in a row of cells
// Insert, delete, count, binary search, sort and read on a list of up to
// DEPTH entries, one command at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. busy stays high
//   until the cycle in which the result is shown; a new command may be taken
//   in that same cycle. rsp_valid marks each result for exactly one cycle and
//   the receiver must take it then. Every command gives exactly one result.
// Steps, from the accept edge to the result:
//   insert and unused opcodes: evaluation only
//   delete, count, read: one sweep, then evaluation; sort: the sort rounds
//   binary search: a sweep and an evaluation for each of at most P probes
//     and one verify, P about log2(fill + 1); an empty list: evaluation only
// The sweeps come from the chain of cells: the prefix match, match count
// and tap of a probed entry move one cell per cycle, so each sweep crosses
// all DEPTH cells, and odd-even transposition sort takes DEPTH rounds.
// Reset empties the list (fill zero); entries themselves are not cleared
// and are only read once written.
// ----------------------------------------------------------------------------
module array_list_engine #(
   parameter int DEPTH = ale_pkg::ALE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_index,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_match_count,
   output logic [3:0]         rsp_position,
   output logic signed [31:0] rsp_read_value,
   output logic [4:0]         rsp_fill
);

   localparam int IW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH+1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_SORT  = 4'b0100,
      ST_EVAL  = 4'b1000
   } ale_state_type;

   ale_state_type state_ff, state_in;
   logic [IW-1:0] ctr_ff, ctr_in;
   logic [2:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [4:0]    idx_ff, idx_in;
   logic [IW-1:0] probe_ff, probe_in;
   logic [FW-1:0] lo_ff, lo_in;
   logic [FW-1:0] hi_ff, hi_in;
   logic          verify_ff, verify_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [4:0]    count_ff, count_in;
   logic [3:0]    pos_ff, pos_in;
   logic [31:0]   rdval_ff, rdval_in;

   ale_pkg::cell_ctl_type  cell_ctl;
   ale_pkg::cell_link_type links [DEPTH];
   logic [FW-1:0]          cnts [DEPTH];

   logic [FW-1:0] total_cnt;
   logic          found;
   logic [31:0]   tap;
   logic [FW-1:0] nlo, nhi;
   logic [FW:0]   mid_sum;

   assign total_cnt = cnts[DEPTH-1] + FW'(links[DEPTH-1].eq);
   assign found     = links[DEPTH-1].seen | links[DEPTH-1].eq;
   assign tap       = links[DEPTH-1].tap;
   assign busy      = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------- cells
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         ale_pkg::cell_link_type left_link;
         logic [FW-1:0]          left_cnt;
         logic [31:0]            right_data;

         if (gi == 0) begin : g_first
            assign left_link = '0;
            assign left_cnt  = '0;
         end else begin : g_rest
            assign left_link = links[gi-1];
            assign left_cnt  = cnts[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_inner
            assign right_data = links[gi+1].data;
         end

         ale_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
         ) u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .pos        (IW'(idx_ff)),
            .probe      (probe_ff),
            .fill       (fill_ff),
            .left_link  (left_link),
            .left_cnt   (left_cnt),
            .right_data (right_data),
            .out_link   (links[gi]),
            .out_cnt    (cnts[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      verify_in    = verify_ff;
      fill_in      = fill_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rdval_in     = rdval_ff;
      cell_ctl.cmd = ale_pkg::CELL_HOLD;
      cell_ctl.key = key_ff;
      nlo          = lo_ff;
      nhi          = hi_ff;
      mid_sum      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               key_in    = req_value;
               idx_in    = req_index;
               ctr_in    = '0;
               verify_in = 1'b0;
               case (req_opcode)
                  ale_pkg::OP_DELETE, ale_pkg::OP_COUNT: begin
                     state_in = ST_SWEEP;
                  end
                  ale_pkg::OP_READ: begin
                     probe_in = IW'(req_index);
                     state_in = ST_SWEEP;
                  end
                  ale_pkg::OP_SEARCH: begin
                     lo_in = '0;
                     hi_in = fill_ff;
                     if (fill_ff != '0) begin
                        probe_in = IW'(fill_ff >> 1);
                        state_in = ST_SWEEP;
                     end else begin
                        verify_in = 1'b1;
                        state_in  = ST_EVAL;
                     end
                  end
                  ale_pkg::OP_SORT: begin
                     state_in = ST_SORT;
                  end
                  default: begin
                     state_in = ST_EVAL;
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            ctr_in = ctr_ff + 1'b1;
            if (ctr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_EVAL;
            end
         end

         ST_SORT: begin
            cell_ctl.cmd = ctr_ff[0] ? ale_pkg::CELL_SORT_ODD : ale_pkg::CELL_SORT_EVEN;
            ctr_in       = ctr_ff + 1'b1;
            if (ctr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = ale_pkg::STATUS_OK;
            count_in     = '0;
            pos_in       = '0;
            rdval_in     = '0;
            case (op_ff)
               ale_pkg::OP_INSERT: begin
                  if (32'(fill_ff) == 32'(DEPTH)) begin
                     status_in = ale_pkg::STATUS_FULL;
                  end else if (32'(idx_ff) > 32'(fill_ff)) begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end else begin
                     cell_ctl.cmd = ale_pkg::CELL_INSERT;
                     fill_in      = fill_ff + 1'b1;
                  end
               end
               ale_pkg::OP_DELETE: begin
                  if (found) begin
                     cell_ctl.cmd = ale_pkg::CELL_DELETE;
                     fill_in      = fill_ff - 1'b1;
                  end else begin
                     status_in = ale_pkg::STATUS_NOT_FOUND;
                  end
               end
               ale_pkg::OP_COUNT: begin
                  count_in = 5'(total_cnt);
                  if (total_cnt == '0) begin
                     status_in = ale_pkg::STATUS_NOT_FOUND;
                  end
               end
               ale_pkg::OP_SEARCH: begin
                  if (verify_ff) begin
                     if ((lo_ff < fill_ff) && (tap == key_ff)) begin
                        pos_in = 4'(lo_ff);
                     end else begin
                        status_in = ale_pkg::STATUS_NOT_FOUND;
                     end
                  end else begin
                     // narrow the bound with the probed entry
                     if ($signed(tap) < $signed(key_ff)) begin
                        nlo = FW'(probe_ff) + 1'b1;
                     end else begin
                        nhi = FW'(probe_ff);
                     end
                     lo_in   = nlo;
                     hi_in   = nhi;
                     mid_sum = {1'b0, nlo} + {1'b0, nhi};
                     ctr_in  = '0;
                     if (nlo < nhi) begin
                        probe_in     = IW'(mid_sum >> 1);
                        state_in     = ST_SWEEP;
                        rsp_valid_in = 1'b0;
                     end else if (nlo < fill_ff) begin
                        probe_in     = IW'(nlo);
                        verify_in    = 1'b1;
                        state_in     = ST_SWEEP;
                        rsp_valid_in = 1'b0;
                     end else begin
                        status_in = ale_pkg::STATUS_NOT_FOUND;
                     end
                  end
               end
               ale_pkg::OP_READ: begin
                  if (32'(idx_ff) < 32'(fill_ff)) begin
                     rdval_in = tap;
                  end else begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end
               end
               default: begin
                  status_in = ale_pkg::STATUS_OK;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         verify_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         verify_ff    <= verify_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      probe_ff  <= probe_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      pos_ff    <= pos_in;
      rdval_ff  <= rdval_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_count = count_ff;
   assign rsp_position    = pos_ff;
   assign rsp_read_value  = rdval_ff;
   assign rsp_fill        = 5'(fill_ff);

   // ---------------------------------------------------------------- checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(DEPTH))
      else $error("fill count exceeds depth");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on back-to-back cycles");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (op_ff == ale_pkg::OP_INSERT) && (rsp_status == ale_pkg::STATUS_OK))
      |-> (fill_ff == FW'($past(fill_ff) + 1'b1)))
      else $error("insert did not grow the list by one");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (op_ff == ale_pkg::OP_DELETE) && (rsp_status == ale_pkg::STATUS_OK))
      |-> (fill_ff == FW'($past(fill_ff) - 1'b1)))
      else $error("delete did not shrink the list by one");

endmodule
